// File: hdl/sbpd_pkg.sv
package sbpd_pkg;

  localparam int unsigned MAX_ROWS    = 32;
  localparam int unsigned COLS_WIDE   = 80;
  localparam int unsigned COLS_NARROW = 40;
  localparam int unsigned CELL_LINES  = 8;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned X_W      = 10;
  localparam int unsigned Y_W      = 8;
  localparam int unsigned COLOUR_W = 4;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PAL_W    = 64;
  localparam int unsigned ROWS_W   = 6;
  localparam int unsigned LINE_W   = 3;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned PIX_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_DATA_W = 24;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MAP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = CFG_IDX_W'(2);

  localparam logic [MODE_W-1:0] MODE_0 = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_1 = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_2 = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_4 = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_5 = MODE_W'(5);

  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_0;
  localparam logic [PAL_W-1:0]  PALETTE_RESET = PAL_W'(64'h70);
  localparam logic [ROWS_W-1:0] ROWS_RESET    = ROWS_W'(32);

  typedef enum logic [1:0] {
    PPC_8,
    PPC_4,
    PPC_2
  } ppc_e;

  typedef struct packed {
    logic [BYTE_W-1:0] screen_byte;
    ppc_e              ppc;
    logic [X_W-1:0]    x0;
    logic [Y_W-1:0]    y;
    logic              frame_end;
  } item_t;

endpackage

// File: hdl/sbpd_front.sv
module sbpd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sbpd_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] screen_byte
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sbpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sbpd_pkg::PAL_W-1:0]     cfg_data_i,
  output logic [sbpd_pkg::PAL_W-1:0]     palette_o,
  output logic                           push_o,
  output sbpd_pkg::item_t                item_o,
  input  logic                           full_i
);
  import sbpd_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [PAL_W-1:0]  palette_q;
  logic [ROWS_W-1:0] rows_q;
  logic [LINE_W-1:0] line_q, line_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  logic              s_accept;
  logic              supported;
  logic              narrow;
  ppc_e              ppc;
  logic [COL_W:0]    cols;
  logic [ROWS_W:0]   rows_eff;
  logic              last_line, last_col, last_row;
  logic [X_W-1:0]    x0;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full_i;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign palette_o     = palette_q;

  always_comb begin
    supported = 1'b1;
    ppc       = PPC_8;
    case (mode_q)
      MODE_0, MODE_4: ppc = PPC_8;
      MODE_1, MODE_5: ppc = PPC_4;
      MODE_2:         ppc = PPC_2;
      default:        supported = 1'b0;
    endcase
  end

  assign narrow = (mode_q == MODE_4) || (mode_q == MODE_5);
  assign cols   = narrow ? (COL_W+1)'(COLS_NARROW) : (COL_W+1)'(COLS_WIDE);

  always_comb begin
    rows_eff = (ROWS_W+1)'(rows_q);
    if (rows_q == '0) begin
      rows_eff = (ROWS_W+1)'(1);
    end else if ((ROWS_W+1)'(rows_q) > (ROWS_W+1)'(MAX_ROWS)) begin
      rows_eff = (ROWS_W+1)'(MAX_ROWS);
    end
  end

  assign last_line = line_q == LINE_W'(CELL_LINES - 1);
  assign last_col  = ((COL_W+1)'(col_q) + (COL_W+1)'(1)) >= cols;
  assign last_row  = ((ROWS_W+1)'(row_q) + (ROWS_W+1)'(1)) >= rows_eff;

  always_comb begin
    case (ppc)
      PPC_8:   x0 = X_W'(col_q) << 3;
      PPC_4:   x0 = X_W'(col_q) << 2;
      default: x0 = X_W'(col_q) << 1;
    endcase
  end

  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    row_d  = row_q;
    if (last_line) begin
      line_d = '0;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end else begin
      line_d = line_q + LINE_W'(1);
    end
  end

  assign push_o             = s_accept && supported;
  assign item_o.screen_byte = s_axis_tdata;
  assign item_o.ppc         = ppc;
  assign item_o.x0          = x0;
  assign item_o.y           = {row_q, line_q};
  assign item_o.frame_end   = last_line && last_col && last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RESET;
      palette_q <= PALETTE_RESET;
      rows_q    <= ROWS_RESET;
      line_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SCREEN_MODE: mode_q    <= cfg_data_i[MODE_W-1:0];
          CFG_PALETTE_MAP: palette_q <= cfg_data_i;
          CFG_ROW_COUNT:   rows_q    <= cfg_data_i[ROWS_W-1:0];
          default: ;
        endcase
      end
      if (push_o) begin
        line_q <= line_d;
        col_q  <= col_d;
        row_q  <= row_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_line_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !last_line) |=> (line_q == $past(line_q) + LINE_W'(1)))
    else $error("line counter did not advance");

  a_drop_unsupported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !supported) |=> ($stable(line_q) && $stable(col_q) && $stable(row_q)))
    else $error("counters moved on a dropped byte");
`endif

endmodule

// File: hdl/sbpd_fifo.sv
module sbpd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbpd_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output sbpd_pkg::item_t item_o,
  output logic            empty_o
);
  import sbpd_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue underflow");
`endif

endmodule

// File: hdl/sbpd_back.sv
module sbpd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [sbpd_pkg::PAL_W-1:0]      palette_i,
  input  logic                            empty_i,
  input  sbpd_pkg::item_t                 item_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [9:0] pixel_x, [17:10] pixel_y, [21:18] pixel_colour, [23:22] zero
  output logic [sbpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,   // frame_done
  output logic                            m_axis_tuser    // byte_done
);
  import sbpd_pkg::*;

  logic [PIX_W-1:0]    pix_q;
  logic                valid_q;
  logic [X_W-1:0]      x_q;
  logic [Y_W-1:0]      y_q;
  logic [COLOUR_W-1:0] colour_q;
  logic                byte_done_q, frame_done_q;

  logic                load;
  logic [PIX_W-1:0]    last_idx;
  logic [X_W-1:0]      x;
  logic [COLOUR_W-1:0] idx;
  logic [COLOUR_W-1:0] colour;
  logic                last_pix;
  logic [BYTE_W-1:0]   b;

  assign b    = item_i.screen_byte;
  assign load = !valid_q || m_axis_tready;

  always_comb begin
    case (item_i.ppc)
      PPC_8: begin
        last_idx = PIX_W'(7);
        x        = item_i.x0 + X_W'(PIX_W'(7) - pix_q);
        idx      = {3'b000, b[pix_q]};
      end
      PPC_4: begin
        last_idx = PIX_W'(3);
        x        = item_i.x0 + X_W'(pix_q);
        idx      = {2'b00, b[PIX_W'(7) - pix_q], b[PIX_W'(3) - pix_q]};
      end
      default: begin
        last_idx = PIX_W'(1);
        x        = item_i.x0 + X_W'(pix_q);
        idx      = {b[PIX_W'(7) - pix_q], b[PIX_W'(5) - pix_q],
                    b[PIX_W'(3) - pix_q], b[PIX_W'(1) - pix_q]};
      end
    endcase
  end

  assign colour   = palette_i[{idx, 2'b00} +: COLOUR_W];
  assign last_pix = pix_q == last_idx;
  assign pop_o    = load && !empty_i && last_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pix_q   <= '0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        pix_q <= last_pix ? '0 : pix_q + PIX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      x_q          <= x;
      y_q          <= item_i.y;
      colour_q     <= colour;
      byte_done_q  <= last_pix;
      frame_done_q <= last_pix && item_i.frame_end;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - X_W - Y_W - COLOUR_W)'(0), colour_q, y_q, x_q};
  assign m_axis_tlast  = frame_done_q;
  assign m_axis_tuser  = byte_done_q;

`ifndef SYNTHESIS
  a_pix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (pix_q <= last_idx))
    else $error("pixel counter past end of byte");

  a_idle_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> (pix_q == '0))
    else $error("pixel counter not cleared with queue empty");
`endif

endmodule

// File: hdl/screen_byte_pixel_decoder.sv
// Screen byte pixel decoder.
// Input stream (s_axis_*): one screen-memory byte per request, in address
// order. Output stream (m_axis_*): one pixel per request with its x, y and
// palette colour; tuser flags the last pixel of a byte, tlast the last pixel
// of the picture. Bytes in modes 3, 6 and 7 are taken and produce nothing.
// Configuration (cfg_*): index 0 screen mode, 1 palette, 2 row count; writes
// are always taken and must be made only while no pixels are outstanding.
// A taken byte is written into the queue; its first pixel is then put in
// the output register. The pixel stage emits one pixel per cycle while the
// receiver takes them: 8 per byte in modes 0/4, 4 in modes 1/5, 2 in mode 2.
// The front takes a byte every cycle while the two-entry queue has room.
// Reset clears the position counters, the queue and the output valid flag
// and loads mode 0, palette 0x70 and 32 rows.
// When the receiver stalls the current pixel holds; the queue fills and then
// tready drops until pixels drain.
module screen_byte_pixel_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sbpd_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] screen_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [9:0] pixel_x, [17:10] pixel_y, [21:18] pixel_colour, [23:22] zero
  output logic [sbpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,   // frame_done
  output logic                            m_axis_tuser,   // byte_done
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sbpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbpd_pkg::PAL_W-1:0]      cfg_data_i
);
  import sbpd_pkg::*;

  logic [PAL_W-1:0] palette;
  logic             push, pop, full, empty;
  item_t            wr_item, rd_item;

  sbpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .palette_o     (palette),
    .push_o        (push),
    .item_o        (wr_item),
    .full_i        (full)
  );

  sbpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (wr_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (rd_item),
    .empty_o (empty)
  );

  sbpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .palette_i     (palette),
    .empty_i       (empty),
    .item_i        (rd_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
